// ----- sv/multichannel_length_prefix_deframer_assert.svh -----
// Assertion macros used by the deframer frame core.
`ifndef MULTICHANNEL_LENGTH_PREFIX_DEFRAMER_ASSERT_SVH
`define MULTICHANNEL_LENGTH_PREFIX_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
`define LPD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lpd assertion failed");
`define LPD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpd implication failed");
`else
`define LPD_ASSERT(lbl, clk, rst, prop)
`define LPD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- sv/lpd_pkg.sv -----
package lpd_pkg;

   localparam int CH_W     = 4;
   localparam int BYTE_W   = 8;
   localparam int CHANNELS = 16;
   // only channels reachable through the 4-bit tag need state
   localparam int DEPTH    = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef struct packed {
      logic [CH_W-1:0]   channel;
      logic [BYTE_W-1:0] data;
   } item_type;

   typedef struct packed {
      logic [CH_W-1:0]   out_channel;
      logic [BYTE_W-1:0] out_byte;
      logic [BYTE_W-1:0] frame_offset;
      logic              frame_end;
      logic              length_error;
   } result_type;

endpackage

// ----- sv/lpd_in_stage.sv -----
module lpd_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lpd_pkg::item_type req_item,
   input  logic              advance,
   output logic              s1_valid,
   output lpd_pkg::item_type s1_item
);
   import lpd_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     load;
   logic     in_range;

   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;
   // words tagged with a channel that has no state are dropped here
   assign in_range  = (32'(req_item.channel) < CHANNELS);

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = in_range;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_item  = item_ff;

endmodule

// ----- sv/lpd_frame_core.sv -----
`include "multichannel_length_prefix_deframer_assert.svh"

module lpd_frame_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                s1_valid,
   input  lpd_pkg::item_type   s1_item,
   output logic                advance,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lpd_pkg::result_type rsp_result
);
   import lpd_pkg::*;

   logic [BYTE_W-1:0] exp_len_ff [DEPTH];
   logic [BYTE_W-1:0] count_ff   [DEPTH];
   logic [BYTE_W-1:0] exp_len_in, count_in;
   logic              rsp_valid_ff;
   result_type        result_ff, result_in;

   logic [IDX_W-1:0]  idx;
   logic [BYTE_W-1:0] cur_len, cur_cnt, eff_len, cnt_inc;
   logic              awaiting_len, zero_len, done, fire;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign fire    = s1_valid && advance;
   assign idx     = s1_item.channel[IDX_W-1:0];

   assign cur_len      = exp_len_ff[idx];
   assign cur_cnt      = count_ff[idx];
   assign awaiting_len = (cur_len == '0);
   assign zero_len     = awaiting_len && (s1_item.data == '0);
   assign eff_len      = awaiting_len ? s1_item.data : cur_len;
   assign cnt_inc      = cur_cnt + BYTE_W'(1);
   assign done         = (cnt_inc >= eff_len);

   always_comb begin
      result_in.out_channel = s1_item.channel;
      result_in.out_byte    = s1_item.data;
      exp_len_in = cur_len;
      count_in   = cur_cnt;
      if (zero_len) begin
         // bad length word: report it, leave the channel waiting
         result_in.frame_offset = '0;
         result_in.frame_end    = 1'b0;
         result_in.length_error = 1'b1;
      end else begin
         result_in.frame_offset = cur_cnt;
         result_in.frame_end    = done;
         result_in.length_error = 1'b0;
         exp_len_in = done ? '0 : eff_len;
         count_in   = done ? '0 : cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            exp_len_ff[i] <= '0;
            count_ff[i]   <= '0;
         end
      end else if (fire) begin
         exp_len_ff[idx] <= exp_len_in;
         count_ff[idx]   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

   `LPD_ASSERT_IMPL(a_err_shape, clock, reset, rsp_valid_ff && result_ff.length_error,
                    result_ff.frame_offset == '0 && !result_ff.frame_end)
   `LPD_ASSERT_IMPL(a_idle_count, clock, reset, s1_valid && awaiting_len, cur_cnt == '0)
   `LPD_ASSERT_IMPL(a_count_below, clock, reset, s1_valid && !awaiting_len,
                    cur_cnt < cur_len)
   `LPD_ASSERT_IMPL(a_state_hold, clock, reset, s1_valid && !advance,
                    ##1 ($stable(exp_len_ff[idx]) && $stable(count_ff[idx])))

endmodule

// ----- sv/multichannel_length_prefix_deframer.sv -----
// Length-prefixed frame deframer for up to 16 interleaved channels. Each
// accepted word is a byte tagged with its channel; the first byte of a frame
// is its length and counts as part of the frame. Every word comes back with
// its channel, its offset in the frame and an end-of-frame flag; a zero
// length byte is flagged as an error and leaves the channel waiting for a
// length. Throughput is one word per cycle while rsp_stall is low: the
// per-channel length and count registers are read and updated between the
// input register and the result register, so consecutive words on the same
// channel need no forwarding. rsp_valid rises once the word has passed the
// input register and then the result register; a stalled result holds the
// input register, so req_stall follows rsp_stall in the same cycle once both
// registers are full. Channels not below CHANNELS are dropped with no result.
module multichannel_length_prefix_deframer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [lpd_pkg::CH_W-1:0]   req_channel,
   input  logic [lpd_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [lpd_pkg::CH_W-1:0]   rsp_out_channel,
   output logic [lpd_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic [lpd_pkg::BYTE_W-1:0] rsp_frame_offset,
   output logic                       rsp_frame_end,
   output logic                       rsp_length_error
);
   import lpd_pkg::*;

   item_type   req_item, s1_item;
   result_type rsp_result;
   logic       s1_valid, advance;

   assign req_item.channel = req_channel;
   assign req_item.data    = req_rx_byte;

   lpd_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .advance   (advance),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item)
   );

   lpd_frame_core u_frame_core (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_item    (s1_item),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_out_channel  = rsp_result.out_channel;
   assign rsp_out_byte     = rsp_result.out_byte;
   assign rsp_frame_offset = rsp_result.frame_offset;
   assign rsp_frame_end    = rsp_result.frame_end;
   assign rsp_length_error = rsp_result.length_error;

endmodule
